FILE: rtl/trilinear_volume_sampler_top_assert.svh
// Assertion macros for the trilinear volume sampler checker.
`ifndef TRILINEAR_VOLUME_SAMPLER_TOP_ASSERT_SVH
`define TRILINEAR_VOLUME_SAMPLER_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define TVS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence starting in the cycle after its trigger.
`define TVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tvs_pkg.sv
// Shared types, constants and helpers of the trilinear volume sampler.
package tvs_pkg;

	// Fixed field formats
	localparam int POS_W     = 13;
	localparam int FRAC_BITS = 8;
	localparam int INT_W     = POS_W - FRAC_BITS;
	localparam int VOX_W     = 16;

	// Weight and accumulator widths
	localparam int WGT_W  = FRAC_BITS + 1;
	localparam int W2_W   = 2 * WGT_W;
	localparam int W3_W   = 3 * WGT_W;
	localparam int PROD_W = VOX_W + W3_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int RES_LSB = 3 * FRAC_BITS;

	// Corner sequencing
	localparam int CORNER_W    = 3;
	localparam int NUM_CORNERS = 8;

	// Default volume dimensions
	localparam int SIZE_X_DEF = 32;
	localparam int SIZE_Y_DEF = 32;
	localparam int SIZE_Z_DEF = 32;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN
	} tvs_state_t;

	// Per-corner control that travels alongside the memory read
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wy;
		logic [WGT_W-1:0] wz;
	} corner_ctl_t;

	// Lower corner gets one minus the fraction, upper corner gets the fraction
	function automatic logic [WGT_W-1:0] axis_weight(input logic upper,
		input logic [FRAC_BITS-1:0] frac);
		logic [WGT_W-1:0] one_w;
		one_w = WGT_W'(1) << FRAC_BITS;
		return upper ? {1'b0, frac} : (one_w - {1'b0, frac});
	endfunction

endpackage

FILE: rtl/tvs_volume_mem.sv
// Single-port voxel memory with registered read data.
module tvs_volume_mem #(
	parameter int AW = 15
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             addr,
	input  logic [tvs_pkg::VOX_W-1:0] wdata,
	output logic [tvs_pkg::VOX_W-1:0] rdata
);
	import tvs_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [VOX_W-1:0] mem [DEPTH];

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/tvs_mac.sv
// Corner weighting and accumulation pipeline behind the voxel memory.
module tvs_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  tvs_pkg::corner_ctl_t      ctl,
	input  logic [tvs_pkg::VOX_W-1:0] rdata,
	output logic                      done,
	output logic [tvs_pkg::VOX_W-1:0] result
);
	import tvs_pkg::*;

	logic              vld_s1, last_s1;
	logic              vld_s2, last_s2;
	logic              vld_s3, last_s3;
	logic [W2_W-1:0]   wxy_s1;
	logic [WGT_W-1:0]  wz_s1;
	logic [W3_W-1:0]   w_s2;
	logic [VOX_W-1:0]  vox_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [ACC_W-1:0]  acc_q;

	// Advance the valid and last flags with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			vld_s1  <= ctl.vld;
			last_s1 <= ctl.vld & ctl.last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			vld_s3  <= vld_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage 1: x by y weight while the memory read is in flight
	// Stage 2: full corner weight, capture the voxel
	// Stage 3: weighted voxel
	always_ff @(posedge clk) begin
		wxy_s1  <= W2_W'(ctl.wx * ctl.wy);
		wz_s1   <= ctl.wz;
		w_s2    <= W3_W'(wxy_s1 * wz_s1);
		vox_s2  <= rdata;
		prod_s3 <= PROD_W'(vox_s2 * w_s2);
	end

	// Clear on a new sample, sum the eight weighted corners
	always_ff @(posedge clk) begin
		if (clr) begin
			acc_q <= '0;
		end else if (vld_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	assign done   = vld_s3 & last_s3;
	assign result = acc_q[RES_LSB +: VOX_W];

endmodule

FILE: rtl/trilinear_volume_sampler_top.sv
// Trilinear volume sampler: a voxel write keeps the input ready; a sample reads its eight corner
// voxels one per cycle from the single-port volume memory, then drains a three-stage
// multiply pipeline and the accumulator, so a sample holds off the input until its result
// is loaded. The volume memory has 2^(clog2 X + clog2 Y + clog2 Z) entries
// addressed as {z, y, x}, comes up undefined and needs no clearing pass; sample only
// positions whose corners were written. Writes outside the volume are dropped, sample
// indices past the last voxel clamp to it. A finished result waits in the output register
// while the next item is taken.
module trilinear_volume_sampler_top #(
	parameter int SIZE_X = tvs_pkg::SIZE_X_DEF,
	parameter int SIZE_Y = tvs_pkg::SIZE_Y_DEF,
	parameter int SIZE_Z = tvs_pkg::SIZE_Z_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [tvs_pkg::POS_W-1:0] pos_x,
	input  logic [tvs_pkg::POS_W-1:0] pos_y,
	input  logic [tvs_pkg::POS_W-1:0] pos_z,
	input  logic [tvs_pkg::VOX_W-1:0] voxel_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [tvs_pkg::VOX_W-1:0] sample_value
);
	import tvs_pkg::*;

	localparam int XW = $clog2(SIZE_X);
	localparam int YW = $clog2(SIZE_Y);
	localparam int ZW = $clog2(SIZE_Z);
	localparam int AW = XW + YW + ZW;
	localparam logic [XW-1:0] X_LAST = XW'(SIZE_X - 1);
	localparam logic [YW-1:0] Y_LAST = YW'(SIZE_Y - 1);
	localparam logic [ZW-1:0] Z_LAST = ZW'(SIZE_Z - 1);

	tvs_state_t state_q, state_d;

	logic [INT_W-1:0]     ix, iy, iz;
	logic                 x_over, y_over, z_over;
	logic [XW-1:0]        x0, x1, x0_q, x1_q, xs;
	logic [YW-1:0]        y0, y1, y0_q, y1_q, ys;
	logic [ZW-1:0]        z0, z1, z0_q, z1_q, zs;
	logic [FRAC_BITS-1:0] fx_q, fy_q, fz_q;
	logic [CORNER_W-1:0]  k_q;
	logic [AW-1:0]        mem_addr;
	logic [VOX_W-1:0]     mem_rdata;
	logic                 in_xfer, sample_xfer, mem_we;
	logic                 load_out, done_q, mac_done;
	logic [VOX_W-1:0]     mac_result;
	logic                 out_valid_q;
	logic [VOX_W-1:0]     sample_value_q;
	corner_ctl_t          ctl;

	// Split positions into integer index and range flags
	assign ix = pos_x[POS_W-1 -: INT_W];
	assign iy = pos_y[POS_W-1 -: INT_W];
	assign iz = pos_z[POS_W-1 -: INT_W];
	assign x_over = 32'(ix) >= 32'(SIZE_X);
	assign y_over = 32'(iy) >= 32'(SIZE_Y);
	assign z_over = 32'(iz) >= 32'(SIZE_Z);

	// Clamp base and upper neighbour to the last index
	assign x0 = x_over ? X_LAST : XW'(ix);
	assign y0 = y_over ? Y_LAST : YW'(iy);
	assign z0 = z_over ? Z_LAST : ZW'(iz);
	assign x1 = (x0 == X_LAST) ? x0 : x0 + 1'b1;
	assign y1 = (y0 == Y_LAST) ? y0 : y0 + 1'b1;
	assign z1 = (z0 == Z_LAST) ? z0 : z0 + 1'b1;

	assign in_xfer     = in_valid & in_ready;
	assign sample_xfer = in_xfer & (operation == OP_SAMPLE);
	assign mem_we      = in_xfer & (operation == OP_WRITE) & ~x_over & ~y_over & ~z_over;

	// Pick the corner for this read cycle
	assign xs = k_q[0] ? x1_q : x0_q;
	assign ys = k_q[1] ? y1_q : y0_q;
	assign zs = k_q[2] ? z1_q : z0_q;

	// Reads own the port while sequencing, writes land only in idle
	assign mem_addr = (state_q == ST_READ) ? {zs, ys, xs}
		: {ZW'(iz), YW'(iy), XW'(ix)};

	always_comb begin
		ctl.vld  = (state_q == ST_READ);
		ctl.last = (k_q == CORNER_W'(NUM_CORNERS - 1));
		ctl.wx   = axis_weight(k_q[0], fx_q);
		ctl.wy   = axis_weight(k_q[1], fy_q);
		ctl.wz   = axis_weight(k_q[2], fz_q);
	end

	tvs_volume_mem #(
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (voxel_value),
		.rdata (mem_rdata)
	);

	tvs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (sample_xfer),
		.ctl    (ctl),
		.rdata  (mem_rdata),
		.done   (mac_done),
		.result (mac_result)
	);

	// Next state, input ready and output load
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && operation == OP_SAMPLE) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (k_q == CORNER_W'(NUM_CORNERS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (done_q && (!out_valid_q || out_ready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state, corner counter, completion flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sample_xfer) begin
				k_q <= '0;
			end else if (state_q == ST_READ) begin
				k_q <= k_q + 1'b1;
			end
			if (mac_done) begin
				done_q <= 1'b1;
			end else if (load_out) begin
				done_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture corner indices and fractions of a sample, and the finished result
	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			x0_q <= x0;
			x1_q <= x1;
			y0_q <= y0;
			y1_q <= y1;
			z0_q <= z0;
			z1_q <= z1;
			fx_q <= pos_x[FRAC_BITS-1:0];
			fy_q <= pos_y[FRAC_BITS-1:0];
			fz_q <= pos_z[FRAC_BITS-1:0];
		end
		if (load_out) begin
			sample_value_q <= mac_result;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = sample_value_q;

endmodule

FILE: rtl/tvs_checker.sv
// Port-level checker for the trilinear volume sampler, bound to the top level.
`include "trilinear_volume_sampler_top_assert.svh"

module tvs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      operation,
	input logic [tvs_pkg::POS_W-1:0] pos_x,
	input logic [tvs_pkg::POS_W-1:0] pos_y,
	input logic [tvs_pkg::POS_W-1:0] pos_z,
	input logic [tvs_pkg::VOX_W-1:0] voxel_value,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [tvs_pkg::VOX_W-1:0] sample_value
);
	import tvs_pkg::*;

	logic sample_xfer, write_xfer;

	assign sample_xfer = in_valid & in_ready & (operation == OP_SAMPLE);
	assign write_xfer  = in_valid & in_ready & (operation == OP_WRITE);

	// A stalled result keeps its value
	`TVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_value), "result changed while stalled")

	// A sample blocks the input at the first and the last of its eight corner reads
	`TVS_ASSERT_NEXT(a_sample_busy, sample_xfer, !in_ready ##7 !in_ready, "input taken during corner reads")

	// A write leaves the block ready for the next item
	`TVS_ASSERT_NEXT(a_write_ready, write_xfer, in_ready, "not ready after a voxel write")

	// Operation and payload carry no unknown bits while valid is high
	`TVS_ASSERT_SAME(a_no_x, in_valid, !$isunknown({pos_x, pos_y, pos_z, voxel_value, operation}), "unknown input")

endmodule

bind trilinear_volume_sampler_top tvs_checker u_tvs_checker (.*);
